FILE: hw/rtl/hsec_pkg.sv
`default_nettype none
package hsec_pkg;

  localparam int unsigned WORD_W = 63;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned PAR_W = 6;
  localparam int unsigned MAX_CODE_BITS_DEF = 63;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_CORRECTED = 2'd1;
  localparam logic [1:0] STATUS_BEYOND = 2'd2;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [LEN_W-1:0]  length;
    logic [WORD_W-1:0] word;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic [LEN_W-1:0]  error_position;
    logic [1:0]        status;
  } rsp_t;

  // Ones in the low n bits.
  function automatic logic [WORD_W-1:0] low_mask(input logic [LEN_W-1:0] n);
    low_mask = ~({WORD_W{1'b1}} << n);
  endfunction

  // Positions q (bit q-1) that have bit i of q set.
  function automatic logic [WORD_W-1:0] group_mask(input int unsigned i);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int unsigned q = 1; q <= WORD_W; q++) begin
      m[q-1] = ((q >> i) & 1) != 0;
    end
    return m;
  endfunction

  // Data bits, lowest first, into the non-power-of-two positions.
  function automatic logic [WORD_W-1:0] scatter(input logic [WORD_W-1:0] data);
    logic [WORD_W-1:0] cw;
    int unsigned di;
    cw = '0;
    di = 0;
    for (int unsigned p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        cw[p-1] = data[di];
        di++;
      end
    end
    return cw;
  endfunction

  // Smallest r with 2^r >= m + r + 1.
  function automatic logic [2:0] calc_r(input logic [LEN_W-1:0] m);
    logic [2:0] r;
    logic found;
    r = 3'd7;
    found = 1'b0;
    for (int unsigned k = 0; k < 8; k++) begin
      if (!found && (32'd1 << k) >= 32'(m) + k + 1) begin
        r = 3'(k);
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hamming_sec_encode_correct_unit.sv
`default_nettype none
// Channel | Signals                      | Item
// --------+------------------------------+-------------------------------------------
// req     | req_valid, req_ready, req    | kind, length, word
// rsp     | rsp_valid, rsp_ready, rsp    | code_word, code_length, error_position, status
//
// One item per cycle while results are taken; rsp_valid rises as the result register loads.
// An input register holds the accepted item, one XOR-tree pass forms the
// codeword or the syndrome, and the result register presents it.
// A waiting result does not block req: the input register takes one more item.
// rst (synchronous, active high) clears both valid flags; payloads are not reset.
module hamming_sec_encode_correct_unit
  import hsec_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  wire  rsp_ready,
  output rsp_t rsp
);

  localparam logic [LEN_W:0] MaxBits = (LEN_W + 1)'(MAX_CODE_BITS);

  // Input register.
  logic s1_valid;
  req_t s1;

  // Result register moves when empty or being taken.
  logic advance;
  assign advance = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
    if (req_valid && req_ready) begin
      s1 <= req;
    end
  end

  // Encode path.
  logic [2:0]        enc_r;
  logic [LEN_W:0]    enc_n;
  logic              enc_bad;
  logic [WORD_W-1:0] enc_data;
  logic [WORD_W-1:0] enc_cw;

  // Check path.
  logic              chk_bad;
  logic [WORD_W-1:0] chk_cw;
  logic [PAR_W-1:0]  chk_syn;

  rsp_t rsp_next;

  always_comb begin
    enc_r = calc_r(s1.length);
    enc_n = {1'b0, s1.length} + (LEN_W + 1)'(enc_r);
    enc_bad = (s1.length == '0) || (enc_n > MaxBits);
    // bits above m are dropped before the scatter, so nothing lands past n
    enc_data = scatter(s1.word & low_mask(s1.length));
    enc_cw = enc_data;
    // parity groups never contain another parity position
    for (int unsigned i = 0; i < PAR_W; i++) begin
      enc_cw[(1 << i) - 1] = ^(enc_data & group_mask(i));
    end

    chk_bad = (s1.length == '0) || ({1'b0, s1.length} > MaxBits);
    chk_cw = s1.word & low_mask(s1.length);
    for (int unsigned i = 0; i < PAR_W; i++) begin
      chk_syn[i] = ^(chk_cw & group_mask(i));
    end

    rsp_next = '0;
    unique case (s1.kind)
      KIND_ENCODE: begin
        if (enc_bad) begin
          rsp_next.status = STATUS_BAD_LEN;
        end else begin
          rsp_next.code_word = enc_cw;
          rsp_next.code_length = enc_n[LEN_W-1:0];
          rsp_next.status = STATUS_OK;
        end
      end
      KIND_CHECK: begin
        if (chk_bad) begin
          rsp_next.status = STATUS_BAD_LEN;
        end else begin
          rsp_next.code_word = chk_cw;
          rsp_next.code_length = s1.length;
          rsp_next.error_position = chk_syn;
          priority if (chk_syn == '0) begin
            rsp_next.status = STATUS_OK;
          end else if (chk_syn <= s1.length) begin
            rsp_next.code_word[chk_syn - 1'b1] = ~chk_cw[chk_syn - 1'b1];
            rsp_next.status = STATUS_CORRECTED;
          end else begin
            // syndrome names a position past the word: report, no flip
            rsp_next.status = STATUS_BEYOND;
          end
        end
      end
      default: begin
        rsp_next.status = STATUS_BAD_LEN;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
  import hsec_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Codewords the block still owes, oldest first
  rsp_t pending_codes[$];

  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;

  // Idle knobs for each side; stall_left is a long receiver hold-off in cycles
  bit send_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int stall_left = 0;

  hamming_sec_encode_correct_unit dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Expected codeword, length, syndrome and status for one item.
  // Encode: data fills the non-power-of-two positions, then each parity
  // position 2^i is set so its group XORs to zero.
  // Check: syndrome over the received length; flip only if it lands inside.
  function automatic rsp_t predict_hamming(input req_t item);
    rsp_t res;
    logic [WORD_W-1:0] cw;
    int m, r, n, di, len, syn;
    logic par;
    res = '0;
    cw = '0;
    syn = 0;
    if (item.kind == KIND_ENCODE) begin
      m = item.length;
      r = 0;
      while ((1 << r) < m + r + 1) r++;
      n = m + r;
      if (m == 0 || n > MAX_CODE_BITS_DEF) begin
        res.status = STATUS_BAD_LEN;
      end else begin
        di = 0;
        for (int p = 1; p <= n; p++) begin
          if ((p & (p - 1)) != 0) begin
            cw[p-1] = item.word[di];
            di++;
          end
        end
        for (int i = 0; (1 << i) <= n; i++) begin
          par = 1'b0;
          for (int q = 1; q <= n; q++) begin
            if (((q >> i) & 1) != 0) par ^= cw[q-1];
          end
          cw[(1 << i) - 1] = par;
        end
        res.code_word = cw;
        res.code_length = LEN_W'(n);
        res.status = STATUS_OK;
      end
    end else begin
      len = item.length;
      if (len == 0 || len > MAX_CODE_BITS_DEF) begin
        res.status = STATUS_BAD_LEN;
      end else begin
        for (int q = 1; q <= len; q++) cw[q-1] = item.word[q-1];
        for (int i = 0; (1 << i) <= len; i++) begin
          par = 1'b0;
          for (int q = 1; q <= len; q++) begin
            if (((q >> i) & 1) != 0) par ^= cw[q-1];
          end
          if (par) syn += (1 << i);
        end
        if (syn == 0) begin
          res.status = STATUS_OK;
        end else if (syn <= len) begin
          cw[syn-1] = ~cw[syn-1];
          res.status = STATUS_CORRECTED;
        end else begin
          res.status = STATUS_BEYOND;
        end
        res.code_word = cw;
        res.code_length = LEN_W'(len);
        res.error_position = LEN_W'(syn);
      end
    end
    return res;
  endfunction

  function automatic req_t mk_req(input logic k, input int unsigned len,
                                  input logic [WORD_W-1:0] w);
    req_t item;
    item.kind = k;
    item.length = LEN_W'(len);
    item.word = w;
    return item;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[WORD_W-1:0];
  endfunction

  // Clean codeword for m data bits
  function automatic rsp_t encode_of(input int unsigned m, input logic [WORD_W-1:0] data);
    return predict_hamming(mk_req(KIND_ENCODE, m, data));
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(input req_t item);
    if (send_gaps && $urandom_range(99) < 6) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result is back
  task automatic wait_results_done();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    fail_count++;
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected cw=%h len=%0d syn=%0d st=%0d",
               want.code_word, want.code_length, want.error_position, want.status);
      $display("  actual   cw=%h len=%0d syn=%0d st=%0d",
               got.code_word, got.code_length, got.error_position, got.status);
    end
  endtask

  // Receiver: long hold-off first, then random idling or always ready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (sink_gaps) begin
      rsp_ready <= ($urandom_range(99) >= 6);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Every accepted item owes exactly one result
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) pending_codes.push_back(predict_hamming(req));
  end

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_codes.size() == 0) begin
        note_mismatch("result with nothing outstanding", '0, rsp);
      end else begin
        want = pending_codes.pop_front();
        if (rsp.code_word !== want.code_word || rsp.code_length !== want.code_length ||
            rsp.error_position !== want.error_position || rsp.status !== want.status)
          note_mismatch("result mismatch", want, rsp);
      end
    end
  end

  // Encode extremes: empty, shortest, longest legal (57 -> 63 bits), too long
  task automatic test_encode_edges();
    send_item(mk_req(KIND_ENCODE, 0, '1));
    send_item(mk_req(KIND_ENCODE, 1, '1));
    send_item(mk_req(KIND_ENCODE, 1, '0));
    send_item(mk_req(KIND_ENCODE, 57, '1));
    send_item(mk_req(KIND_ENCODE, 57, '0));
    send_item(mk_req(KIND_ENCODE, 58, '1));
    send_item(mk_req(KIND_ENCODE, 63, '1));
    send_item(mk_req(KIND_ENCODE, 4, 63'b1011));
    send_item(mk_req(KIND_ENCODE, 26, WORD_W'({32{2'b10}})));
    // junk above the data bits must not leak into the codeword
    send_item(mk_req(KIND_ENCODE, 11, {52'hF0F0_F0F0_F0F0_F, 11'h5A5}));
  endtask

  // Check extremes: bad length, clean, parity and data errors, syndrome past the end
  task automatic test_check_edges();
    rsp_t full;
    rsp_t seven;
    full = encode_of(57, '1);
    seven = encode_of(4, 63'b1011);
    send_item(mk_req(KIND_CHECK, 0, '1));
    send_item(mk_req(KIND_CHECK, 63, full.code_word));
    send_item(mk_req(KIND_CHECK, 63, full.code_word ^ (63'd1 << 62)));
    send_item(mk_req(KIND_CHECK, 63, full.code_word ^ 63'd1));
    send_item(mk_req(KIND_CHECK, 63, '1));
    send_item(mk_req(KIND_CHECK, 63, '0));
    send_item(mk_req(KIND_CHECK, 1, '1));
    send_item(mk_req(KIND_CHECK, 5, 63'b01010));
    send_item(mk_req(KIND_CHECK, 6, 63'b001100));
    send_item(mk_req(KIND_CHECK, 7, seven.code_word ^ 63'b10000 ^ ({63{1'b1}} << 7)));
    send_item(mk_req(KIND_CHECK, 3, 63'b100 | ({63{1'b1}} << 3)));
    send_item(mk_req(KIND_CHECK, 2, 63'b10));
  endtask

  // Mostly well-formed codewords (clean or one flip), plus encodes and noise
  task automatic send_random_item();
    int unsigned sel, m, n;
    rsp_t enc;
    logic [WORD_W-1:0] cw;
    sel = $urandom_range(99);
    if (sel < 30) begin
      m = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(1, 57);
      send_item(mk_req(KIND_ENCODE, m, rand_word()));
    end else if (sel < 85) begin
      m = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 57);
      enc = encode_of(m, rand_word());
      cw = enc.code_word;
      n = enc.code_length;
      if ($urandom_range(3) != 0) cw[$urandom_range(n - 1)] ^= 1'b1;
      if ($urandom_range(1) == 0) cw |= rand_word() << n;
      send_item(mk_req(KIND_CHECK, n, cw));
    end else begin
      send_item(mk_req(KIND_CHECK, $urandom_range(63), rand_word()));
    end
  endtask

  // Receiver goes dark while the sender keeps pushing; block must stall its input
  task automatic test_backpressure();
    send_gaps = 1'b0;
    stall_left = 150;
    repeat (30) send_random_item();
    send_gaps = 1'b1;
  endtask

  task automatic test_random(input int unsigned count, input bit gaps);
    send_gaps = gaps;
    sink_gaps = gaps;
    repeat (count) send_random_item();
    send_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_edges();
    wait_results_done();
    test_check_edges();
    wait_results_done();
    test_backpressure();
    wait_results_done();
    test_random(1000, 1'b1);
    test_random(250, 1'b0);
    wait_results_done();
    // pipeline is two deep; give it room to show any stray result
    repeat (8) @(posedge clk);
    if (pending_codes.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", pending_codes.size());
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/hsec_pkg.sv
hw/rtl/hamming_sec_encode_correct_unit.sv
tb/tb.sv
